/* design/arfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive frame parser package
// Shared types, codes and constants for the API receive frame parser.
// ----------------------------------------------------------------------------
package arfp_pkg;

   localparam int PAYLOAD_DEPTH_DEFAULT = 256;

   localparam int HDR_BYTES = 11;
   localparam logic [15:0] HEADER_LEN = 16'd12;

   localparam logic [7:0] RST_CONNECT_CODE = 8'h00;
   localparam logic [7:0] RST_START_DELIMITER = 8'h7E;
   localparam logic [7:0] RST_RX_FRAME_TYPE = 8'h90;

   localparam logic [1:0] CSR_CONNECTED = 2'd0;
   localparam logic [1:0] CSR_CONNECT_CODE = 2'd1;
   localparam logic [1:0] CSR_START_DELIMITER = 2'd2;
   localparam logic [1:0] CSR_RX_FRAME_TYPE = 2'd3;

   typedef enum logic [1:0] {
      REQ_LINE_BYTE = 2'd0,
      REQ_READ      = 2'd1,
      REQ_DISCARD   = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_BAD_CHECKSUM  = 2'd1,
      STATUS_NOT_CONNECTED = 2'd2,
      STATUS_OVERFLOW      = 2'd3
   } frame_status_type;

   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_LEN_HI  = 7'b0000010,
      PH_LEN_LO  = 7'b0000100,
      PH_TYPE    = 7'b0001000,
      PH_HEADER  = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_CHECK   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       connected;
      logic [7:0] connect_code;
      logic [7:0] start_delimiter;
      logic [7:0] rx_frame_type;
   } cfg_type;

endpackage

/* design/api_rx_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// API receive frame parser
// Parses received radio API frames byte by byte and stores their payload.
// ----------------------------------------------------------------------------
// The req channel carries one request per transaction: req_tuser selects a
// received line byte, a payload read or a message discard, and req_tdata
// holds the line byte. Every request yields exactly one rsp transaction
// with the frame result, the stored length, any read byte and the ready and
// busy marks as they stand after the request.
// The block takes one request per cycle while responses are taken. A
// request is held in the input register; when the output is free, one pass
// of the frame state update then loads the result register, together with
// the payload memory read, and raises rsp_tvalid.
// When rsp_tready is low the result register holds, the input register
// fills, and req_tready then drops until the result is taken.
// Reset clears the frame state except the first payload byte, the ready and
// busy marks and both pipeline valid bits, and loads the configuration
// defaults. The payload memory is not cleared; only bytes written by a frame
// are ever returned. The csr port writes one configuration register per cycle
// with csr_we high and is meant to be used while no transaction is in flight.
// ----------------------------------------------------------------------------
module api_rx_frame_parser
   import arfp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] frame_done, [2:1] frame_status, [11:3] payload_length,
   // [19:12] read_data, [20] read_valid, [21] message_ready, [22] busy_res
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = $clog2(PAYLOAD_DEPTH);

   cfg_type         cfg;
   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [7:0]      mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   logic [7:0]      mem_rd_data;

   arfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   arfp_store #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   arfp_core #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .req_kind    (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

/* design/arfp_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive frame parser configuration registers
// Holds the link state and the framing bytes written through the CSR port.
// ----------------------------------------------------------------------------
module arfp_csr
   import arfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.connected       <= 1'b0;
         cfg_ff.connect_code    <= RST_CONNECT_CODE;
         cfg_ff.start_delimiter <= RST_START_DELIMITER;
         cfg_ff.rx_frame_type   <= RST_RX_FRAME_TYPE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CONNECTED:       cfg_ff.connected       <= csr_wdata[0];
            CSR_CONNECT_CODE:    cfg_ff.connect_code    <= csr_wdata;
            CSR_START_DELIMITER: cfg_ff.start_delimiter <= csr_wdata;
            CSR_RX_FRAME_TYPE:   cfg_ff.rx_frame_type   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/arfp_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive frame parser payload store
// Single write port, single registered read port byte memory.
// ----------------------------------------------------------------------------
module arfp_store
   import arfp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(PAYLOAD_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                       wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(PAYLOAD_DEPTH)-1:0] rd_addr,
   output logic [7:0]                       rd_data
);

   logic [7:0] mem [PAYLOAD_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/arfp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive frame parser core
// Input register, per-byte frame state update and result register.
// ----------------------------------------------------------------------------
module arfp_core
   import arfp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_byte,
   input  logic [1:0]                       req_kind,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,
   output logic                             mem_wr_en,
   output logic [$clog2(PAYLOAD_DEPTH)-1:0] mem_wr_addr,
   output logic [7:0]                       mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(PAYLOAD_DEPTH)-1:0] mem_rd_addr,
   input  logic [7:0]                       mem_rd_data
);

   localparam int AW = $clog2(PAYLOAD_DEPTH);
   localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PAYLOAD_DEPTH);
   localparam logic [3:0] HDR_CNT_LAST = 4'(HDR_BYTES - 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic [1:0]       in_kind_ff;
   logic             out_valid_ff, out_valid_in;
   logic             done_ff, done_in;
   frame_status_type status_ff, status_in;
   logic             rvalid_ff, rvalid_in;

   phase_type        phase_ff, phase_in;
   logic [3:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]      dlen_ff, dlen_in;
   logic [7:0]       sum_ff, sum_in;
   logic [CNT_W-1:0] wr_idx_ff, wr_idx_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       first_byte_ff, first_byte_in;
   logic [CNT_W-1:0] stored_len_ff, stored_len_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             ready_ff, ready_in;
   logic             busy_ff, busy_in;

   logic             advance;
   logic             proc;
   logic [15:0]      dlen_dec;
   logic [CNT_W-1:0] rd_idx_next;

   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign proc = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      dlen_in       = dlen_ff;
      sum_in        = sum_ff;
      wr_idx_in     = wr_idx_ff;
      ovf_in        = ovf_ff;
      first_byte_in = first_byte_ff;
      stored_len_in = stored_len_ff;
      rd_idx_in     = rd_idx_ff;
      ready_in      = ready_ff;
      busy_in       = busy_ff;
      done_in       = 1'b0;
      status_in     = STATUS_OK;
      rvalid_in     = 1'b0;
      mem_wr_en     = 1'b0;
      dlen_dec      = (dlen_ff != 16'd0) ? dlen_ff - 16'd1 : dlen_ff;
      rd_idx_next   = rd_idx_ff;
      if (proc) begin
         case (req_kind_type'(in_kind_ff))
            REQ_LINE_BYTE: begin
               case (phase_ff)
                  PH_LEN_HI: begin
                     dlen_in  = {in_byte_ff, 8'h00};
                     phase_in = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     dlen_in  = {dlen_ff[15:8], in_byte_ff};
                     phase_in = PH_TYPE;
                  end
                  PH_TYPE: begin
                     if (in_byte_ff != cfg.rx_frame_type) begin
                        phase_in = PH_HUNT;
                        busy_in  = 1'b0;
                     end else begin
                        sum_in     = in_byte_ff;
                        hdr_cnt_in = 4'd0;
                        phase_in   = PH_HEADER;
                     end
                  end
                  PH_HEADER: begin
                     sum_in   = sum_ff + in_byte_ff;
                     ready_in = 1'b0;
                     if (hdr_cnt_ff != HDR_CNT_LAST) begin
                        hdr_cnt_in = hdr_cnt_ff + 4'd1;
                     end else if (dlen_ff <= HEADER_LEN) begin
                        phase_in = PH_CHECK;
                     end else begin
                        dlen_in  = dlen_ff - HEADER_LEN;
                        phase_in = PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     sum_in = sum_ff + in_byte_ff;
                     if (wr_idx_ff < DEPTH_CNT) begin
                        mem_wr_en = 1'b1;
                        wr_idx_in = wr_idx_ff + CNT_W'(1);
                        if (wr_idx_ff == '0) begin
                           first_byte_in = in_byte_ff;
                        end
                     end else begin
                        ovf_in = 1'b1;
                     end
                     dlen_in = dlen_dec;
                     if (dlen_dec == 16'd0) begin
                        phase_in = PH_CHECK;
                     end
                  end
                  PH_CHECK: begin
                     done_in  = 1'b1;
                     phase_in = PH_HUNT;
                     busy_in  = 1'b0;
                     if (ovf_ff) begin
                        status_in = STATUS_OVERFLOW;
                        ready_in  = 1'b0;
                     end else if (~sum_ff != in_byte_ff) begin
                        status_in = STATUS_BAD_CHECKSUM;
                     end else begin
                        stored_len_in = wr_idx_ff;
                        if (!cfg.connected &&
                            (wr_idx_ff == '0 || first_byte_ff != cfg.connect_code)) begin
                           status_in = STATUS_NOT_CONNECTED;
                           ready_in  = 1'b0;
                        end else begin
                           status_in = STATUS_OK;
                           ready_in  = 1'b1;
                           rd_idx_in = '0;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_HUNT;
                     if (in_byte_ff == cfg.start_delimiter) begin
                        wr_idx_in = '0;
                        ovf_in    = 1'b0;
                        busy_in   = 1'b1;
                        phase_in  = PH_LEN_HI;
                     end
                  end
               endcase
            end
            REQ_READ: begin
               if (ready_ff) begin
                  if (rd_idx_ff < stored_len_ff) begin
                     rvalid_in   = 1'b1;
                     rd_idx_next = rd_idx_ff + CNT_W'(1);
                  end
                  if (rd_idx_next >= stored_len_ff) begin
                     rd_idx_in = '0;
                     ready_in  = 1'b0;
                  end else begin
                     rd_idx_in = rd_idx_next;
                  end
               end
            end
            REQ_DISCARD: begin
               ready_in  = 1'b0;
               rd_idx_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign mem_wr_addr = wr_idx_ff[AW-1:0];
   assign mem_wr_data = in_byte_ff;
   assign mem_rd_en   = proc;
   assign mem_rd_addr = rd_idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         hdr_cnt_ff   <= 4'd0;
         dlen_ff      <= 16'd0;
         sum_ff       <= 8'd0;
         wr_idx_ff    <= '0;
         ovf_ff       <= 1'b0;
         stored_len_ff <= '0;
         rd_idx_ff    <= '0;
         ready_ff     <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         dlen_ff      <= dlen_in;
         sum_ff       <= sum_in;
         wr_idx_ff    <= wr_idx_in;
         ovf_ff       <= ovf_in;
         stored_len_ff <= stored_len_in;
         rd_idx_ff    <= rd_idx_in;
         ready_ff     <= ready_in;
         busy_ff      <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_byte;
         in_kind_ff <= req_kind;
      end
      if (advance) begin
         done_ff   <= done_in;
         status_ff <= status_in;
         rvalid_ff <= rvalid_in;
      end
      first_byte_ff <= first_byte_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, busy_ff, ready_ff, rvalid_ff,
                        rvalid_ff ? mem_rd_data : 8'h00,
                        9'(stored_len_ff), status_ff, done_ff};

   a_no_ready_while_storing : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD || phase_ff == PH_CHECK) |-> !ready_ff)
      else $error("Message marked ready while payload bytes are being stored.");

   a_read_index_in_range : assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (rd_idx_ff < stored_len_ff) ||
                   (stored_len_ff == '0 && rd_idx_ff == '0))
      else $error("Read index is outside the published message.");

   a_write_index_bound : assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= DEPTH_CNT)
      else $error("Write index ran past the payload store.");

   a_status_only_on_done : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !done_ff) |-> status_ff == STATUS_OK)
      else $error("Frame status reported without a completed frame.");

   a_busy_starts_frame : assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> phase_ff == PH_LEN_HI)
      else $error("Busy rose without a start delimiter.");

endmodule

/* tb/tb_api_rx_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the API receive frame parser
// Feeds line bytes, payload reads, discards and unknown requests through the
// request stream and keeps a cycle-free model of the parser. Every response
// transaction is compared field by field with the model. The run covers
// short, typical and overflowing frames, bad checksums, wrong frame types
// and connect filtering, under several register settings and several
// patterns of idle and stall cycles on both streams.
// ----------------------------------------------------------------------------
module tb_api_rx_frame_parser;
   import arfp_pkg::*;

   localparam int MSG_DEPTH = PAYLOAD_DEPTH_DEFAULT;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef enum logic [2:0] {
      SEEK_DELIM,
      SEEK_LEN_HI,
      SEEK_LEN_LO,
      SEEK_TYPE,
      IN_HEADER,
      IN_PAYLOAD,
      AT_CHECKSUM
   } parse_step_type;

   typedef struct packed {
      logic             spare;
      logic             busy_res;
      logic             message_ready;
      logic             read_valid;
      logic [7:0]       read_data;
      logic [8:0]       payload_length;
      frame_status_type frame_status;
      logic             frame_done;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // Parser model state.
   cfg_type        cfg_model;
   parse_step_type rx_phase;
   logic [15:0]    frame_len;
   logic [7:0]     chk_sum;
   int             hdr_left;
   logic [8:0]     wr_ptr;
   logic           overflowed;
   logic [7:0]     msg_bytes [MSG_DEPTH];
   logic [8:0]     msg_len;
   logic [8:0]     rd_ptr;
   logic           msg_ready;
   logic           frame_busy;

   frame_result_type parser_replies [$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int items_sent = 0;
   int mismatches = 0;
   int bytes_read = 0;
   int frames_by_status [4] = '{0, 0, 0, 0};

   api_rx_frame_parser #(
      .PAYLOAD_DEPTH(MSG_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic void clear_parser();
      cfg_model.connected = 1'b0;
      cfg_model.connect_code = RST_CONNECT_CODE;
      cfg_model.start_delimiter = RST_START_DELIMITER;
      cfg_model.rx_frame_type = RST_RX_FRAME_TYPE;
      rx_phase = SEEK_DELIM;
      frame_len = '0;
      chk_sum = '0;
      hdr_left = 0;
      wr_ptr = '0;
      overflowed = 1'b0;
      msg_len = '0;
      rd_ptr = '0;
      msg_ready = 1'b0;
      frame_busy = 1'b0;
   endfunction

   function automatic frame_result_type advance_parser(input logic [1:0] kind,
                                                       input logic [7:0] b);
      frame_result_type r;
      r = '0;
      if (kind == REQ_LINE_BYTE) begin
         case (rx_phase)
            SEEK_LEN_HI: begin
               frame_len[15:8] = b;
               rx_phase = SEEK_LEN_LO;
            end
            SEEK_LEN_LO: begin
               frame_len[7:0] = b;
               rx_phase = SEEK_TYPE;
            end
            SEEK_TYPE: begin
               if (b != cfg_model.rx_frame_type) begin
                  rx_phase = SEEK_DELIM;
                  frame_busy = 1'b0;
               end else begin
                  chk_sum = b;
                  hdr_left = HDR_BYTES;
                  rx_phase = IN_HEADER;
               end
            end
            IN_HEADER: begin
               chk_sum = chk_sum + b;
               msg_ready = 1'b0;
               hdr_left--;
               if (hdr_left == 0) begin
                  if (frame_len <= HEADER_LEN) begin
                     rx_phase = AT_CHECKSUM;
                  end else begin
                     frame_len = frame_len - HEADER_LEN;
                     rx_phase = IN_PAYLOAD;
                  end
               end
            end
            IN_PAYLOAD: begin
               chk_sum = chk_sum + b;
               if (wr_ptr < MSG_DEPTH) begin
                  msg_bytes[wr_ptr] = b;
                  wr_ptr++;
               end else begin
                  overflowed = 1'b1;
               end
               if (frame_len > 0) frame_len--;
               if (frame_len == 0) rx_phase = AT_CHECKSUM;
            end
            AT_CHECKSUM: begin
               r.frame_done = 1'b1;
               if (overflowed) begin
                  r.frame_status = STATUS_OVERFLOW;
                  msg_ready = 1'b0;
               end else if (8'(8'hFF - chk_sum) != b) begin
                  r.frame_status = STATUS_BAD_CHECKSUM;
               end else begin
                  msg_len = wr_ptr;
                  if (!cfg_model.connected &&
                      (wr_ptr == 0 || msg_bytes[0] != cfg_model.connect_code)) begin
                     r.frame_status = STATUS_NOT_CONNECTED;
                     msg_ready = 1'b0;
                  end else begin
                     r.frame_status = STATUS_OK;
                     msg_ready = 1'b1;
                     rd_ptr = '0;
                  end
               end
               frames_by_status[r.frame_status]++;
               rx_phase = SEEK_DELIM;
               frame_busy = 1'b0;
            end
            default: begin
               rx_phase = SEEK_DELIM;
               if (b == cfg_model.start_delimiter) begin
                  wr_ptr = '0;
                  overflowed = 1'b0;
                  frame_busy = 1'b1;
                  rx_phase = SEEK_LEN_HI;
               end
            end
         endcase
      end else if (kind == REQ_READ) begin
         if (msg_ready) begin
            if (rd_ptr < msg_len) begin
               r.read_data = msg_bytes[rd_ptr];
               r.read_valid = 1'b1;
               rd_ptr++;
               bytes_read++;
            end
            if (rd_ptr >= msg_len) begin
               rd_ptr = '0;
               msg_ready = 1'b0;
            end
         end
      end else if (kind == REQ_DISCARD) begin
         msg_ready = 1'b0;
         rd_ptr = '0;
      end
      r.payload_length = msg_len;
      r.message_ready = msg_ready;
      r.busy_res = frame_busy;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_CONNECTED:       cfg_model.connected = csr_wdata[0];
               CSR_CONNECT_CODE:    cfg_model.connect_code = csr_wdata;
               CSR_START_DELIMITER: cfg_model.start_delimiter = csr_wdata;
               CSR_RX_FRAME_TYPE:   cfg_model.rx_frame_type = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            parser_replies.push_back(advance_parser(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (parser_replies.size() == 0) begin
               $error("response transaction %h with none outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = parser_replies.pop_front();
               check_field("frame_done", want.frame_done, got.frame_done);
               check_field("frame_status", want.frame_status, got.frame_status);
               check_field("payload_length", want.payload_length, got.payload_length);
               check_field("read_data", want.read_data, got.read_data);
               check_field("read_valid", want.read_valid, got.read_valid);
               check_field("message_ready", want.message_ready, got.message_ready);
               check_field("busy_res", want.busy_res, got.busy_res);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [7:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (parser_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_frame(input logic [15:0] decl_len, input bit connect_msg,
                             input bit bad_sum, input bit bad_type);
      logic [7:0] ftype;
      logic [7:0] sum;
      logic [7:0] b;
      int n_payload;
      ftype = cfg_model.rx_frame_type;
      if (bad_type) ftype = ftype ^ 8'($urandom_range(1, 255));
      n_payload = (decl_len > HEADER_LEN) ? int'(decl_len) - int'(HEADER_LEN) : 0;
      send_item(REQ_LINE_BYTE, cfg_model.start_delimiter);
      send_item(REQ_LINE_BYTE, decl_len[15:8]);
      send_item(REQ_LINE_BYTE, decl_len[7:0]);
      send_item(REQ_LINE_BYTE, ftype);
      if (!bad_type) begin
         sum = ftype;
         for (int i = 0; i < HDR_BYTES + n_payload; i++) begin
            b = 8'($urandom);
            if (i == HDR_BYTES && connect_msg) b = cfg_model.connect_code;
            sum = sum + b;
            send_item(REQ_LINE_BYTE, b);
         end
         b = 8'hFF - sum;
         if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
         send_item(REQ_LINE_BYTE, b);
      end
   endtask

   task automatic send_random_frame();
      logic [15:0] len;
      if ($urandom_range(9) < 2) len = 16'($urandom_range(12));
      else len = 16'(13 + $urandom_range(20));
      send_frame(len, 1'($urandom_range(1)), $urandom_range(7) == 0, 1'b0);
   endtask

   task automatic run_traffic(input int n_items);
      int stop_at;
      int pick;
      logic [7:0] b;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_random_frame();
         end else if (pick < 80) begin
            repeat ($urandom_range(1, msg_len + 1)) send_item(REQ_READ, 8'($urandom));
         end else if (pick < 86) begin
            send_item(REQ_DISCARD, 8'($urandom));
         end else if (pick < 90) begin
            send_item(REQ_UNKNOWN, 8'($urandom));
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom);
               if (b == cfg_model.start_delimiter) b = b ^ 8'h01;
               send_item(REQ_LINE_BYTE, b);
            end
         end else begin
            send_frame(16'($urandom), 1'b0, 1'b0, 1'b1);
         end
      end
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(REQ_READ, 8'hFF);
      send_item(REQ_UNKNOWN, 8'h00);
      send_item(REQ_DISCARD, 8'hA5);
      send_frame(16'hFFFF, 1'b0, 1'b0, 1'b1);
      send_frame(16'h0000, 1'b0, 1'b0, 1'b0);
      wait_drain();
   endtask

   task automatic test_payload_limits();
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      write_csr(CSR_CONNECTED, 8'h01);
      send_frame(HEADER_LEN, 1'b0, 1'b0, 1'b0);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_READ, 8'h00);
      send_frame(16'(HEADER_LEN + 5), 1'b0, 1'b0, 1'b0);
      repeat (3) send_item(REQ_READ, 8'($urandom));
      send_frame(16'(HEADER_LEN + MSG_DEPTH + 1), 1'b0, 1'b0, 1'b0);
      send_item(REQ_READ, 8'h00);
      wait_drain();
   endtask

   task automatic test_register_sweep();
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               write_csr(CSR_CONNECTED, 8'h00);
               write_csr(CSR_CONNECT_CODE, 8'h00);
               write_csr(CSR_START_DELIMITER, 8'h7E);
               write_csr(CSR_RX_FRAME_TYPE, 8'h90);
            end
            1: begin
               send_idle_pct = 72;
               rsp_stall_pct = 0;
               write_csr(CSR_CONNECTED, 8'h01);
               write_csr(CSR_CONNECT_CODE, 8'hFF);
               write_csr(CSR_START_DELIMITER, 8'h00);
               write_csr(CSR_RX_FRAME_TYPE, 8'hFF);
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 72;
               write_csr(CSR_CONNECTED, 8'hFE);
               write_csr(CSR_CONNECT_CODE, 8'($urandom));
               write_csr(CSR_START_DELIMITER, 8'hFF);
               write_csr(CSR_RX_FRAME_TYPE, 8'h00);
            end
            default: begin
               send_idle_pct = 20;
               rsp_stall_pct = 20;
               write_csr(CSR_CONNECTED, 8'($urandom) | 8'h01);
               write_csr(CSR_CONNECT_CODE, 8'($urandom));
               write_csr(CSR_START_DELIMITER, 8'($urandom));
               write_csr(CSR_RX_FRAME_TYPE, 8'($urandom));
            end
         endcase
         run_traffic(35);
         wait_drain();
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_request = 80;
      send_random_frame();
      send_random_frame();
      repeat (8) send_item(REQ_READ, 8'($urandom));
      wait_drain();
   endtask

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_payload_limits();
      test_register_sweep();
      test_backpressure();
      wait_drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d transactions across four register settings and idle patterns.",
               items_sent);
      $display("Frames: %0d published, %0d bad checksum, %0d dropped, %0d overflow;",
               frames_by_status[STATUS_OK], frames_by_status[STATUS_BAD_CHECKSUM],
               frames_by_status[STATUS_NOT_CONNECTED], frames_by_status[STATUS_OVERFLOW]);
      $display("%0d payload bytes read back.", bytes_read);
      if (mismatches == 0) begin
         $display("tb_api_rx_frame_parser: PASS");
      end else begin
         $display("tb_api_rx_frame_parser: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_api_rx_frame_parser: FAIL");
      $finish;
   end

endmodule

/* sim.f */
design/arfp_pkg.sv
design/arfp_csr.sv
design/arfp_store.sv
design/arfp_core.sv
design/api_rx_frame_parser.sv
tb/tb_api_rx_frame_parser.sv
